/* src/u2a_pkg.sv */
// u2a_pkg: shared types, constants and the transliteration table for the
// UTF-8 to ASCII transliterator. No dependencies.
package u2a_pkg;

	localparam logic [15:0] CAP_RESET   = 16'd256;
	localparam logic [6:0]  CH_NUL      = 7'h00;
	localparam logic [6:0]  CH_QMARK    = 7'h3F;
	localparam logic [6:0]  CH_DOT      = 7'h2E;
	localparam logic [20:0] CP_ELLIPSIS = 21'h02026;

	// Decoder state carried from byte to byte
	typedef struct packed {
		logic [2:0]  total;   // pending sequence length, 0 = none
		logic [1:0]  seen;    // continuation bytes gathered
		logic [20:0] accum;   // code point bits so far
		logic [15:0] cw;      // characters written this string
		logic        full;    // output capacity reached
	} state_t;

	// Results produced for one input byte, entry 0 goes out first
	typedef struct packed {
		logic [3:0][6:0] chars;
		logic [2:0]      cnt;
		logic            last;  // final entry is the terminator
	} res_t;

	typedef struct packed {
		logic [1:0] len;   // 0 = no mapping
		logic [6:0] c0;
		logic [6:0] c1;
	} xlat_t;

	function automatic xlat_t xlat(input logic [20:0] cp);
		xlat_t r;
		r = '{len: 2'd0, c0: CH_QMARK, c1: CH_QMARK};
		unique case (cp)
			21'h000E4: r = '{len: 2'd2, c0: 7'h61, c1: 7'h65};  // ae
			21'h000C4: r = '{len: 2'd2, c0: 7'h41, c1: 7'h65};  // Ae
			21'h000F6: r = '{len: 2'd2, c0: 7'h6F, c1: 7'h65};  // oe
			21'h000D6: r = '{len: 2'd2, c0: 7'h4F, c1: 7'h65};  // Oe
			21'h000FC: r = '{len: 2'd2, c0: 7'h75, c1: 7'h65};  // ue
			21'h000DC: r = '{len: 2'd2, c0: 7'h55, c1: 7'h65};  // Ue
			21'h000DF: r = '{len: 2'd2, c0: 7'h73, c1: 7'h73};  // ss
			21'h02013,
			21'h02014: r = '{len: 2'd1, c0: 7'h2D, c1: CH_QMARK};
			21'h02018,
			21'h02019: r = '{len: 2'd1, c0: 7'h27, c1: CH_QMARK};
			21'h0201C,
			21'h0201D: r = '{len: 2'd1, c0: 7'h22, c1: CH_QMARK};
			default:   r = '{len: 2'd0, c0: CH_QMARK, c1: CH_QMARK};
		endcase
		return r;
	endfunction

endpackage

/* src/utf8_to_ascii_transliterator.sv */
// utf8_to_ascii_transliterator: top level with input register, decoder
// state and capacity register. Depends on u2a_pkg, u2a_decode, u2a_outbuf.
//
// Takes a NUL-terminated UTF-8 string one byte per slave transaction and
// returns ASCII characters on the master stream, one per transaction.
// A byte is accepted into an input register, decoded combinationally and
// its results (zero to four characters) loaded into a result register, so
// the first character is offered on the master side from the result
// register once the byte has passed through both registers. Each byte that
// yields at most one character sustains one byte per cycle while m_tready
// stays high; a byte yielding more than one character holds the result
// register until the master side, which drains one character per cycle
// while m_tready is high, has taken all of them. Multi-byte sequences, the
// fourteen transliterated code points, broken-sequence '?' flushing and
// the capacity cut-off are handled as the string streams. A NUL byte
// flushes any pending sequence and, when out_capacity is nonzero, closes
// the string with a zero character marked by tlast. cfg_wdata is written
// to out_capacity (reset 256) whenever cfg_we is high; write it only while
// the block is idle.
module utf8_to_ascii_transliterator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,   // out_capacity
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // [7:0] in_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,     // [6:0] out_char, [7] zero
	output logic        m_tlast      // end_of_string
);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic [15:0]     cap_q;
	u2a_pkg::state_t st_q;
	u2a_pkg::state_t st_n;
	u2a_pkg::res_t   res;
	logic            can_load;
	logic            fire;

	// decode fires when the result register is free or frees this cycle
	assign fire = valid_s1 && can_load;
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			byte_s1 <= s_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= u2a_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire) begin
			st_q <= st_n;
		end
	end

	u2a_decode u_decode (
		.in_byte (byte_s1),
		.cap     (cap_q),
		.st      (st_q),
		.st_n    (st_n),
		.res     (res)
	);

	u2a_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (fire),
		.res      (res),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// a zero character only ever closes a string
	a_nul_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[6:0] == u2a_pkg::CH_NUL |-> m_tlast)
		else $error("zero character without tlast");

	// pending sequence always has room for at least one more byte
	a_seq_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.total != 3'd0 |-> ({1'b0, st_q.seen} + 3'd1 < st_q.total)
			&& (st_q.total == 3'd2 || st_q.total == 3'd3 || st_q.total == 3'd4))
		else $error("sequence counters out of range");

	// a NUL leaves the decoder fully cleared
	a_nul_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && byte_s1 == 8'd0 |=> st_q == '0)
		else $error("state not cleared after NUL");

	// results of a decoded byte show up on the next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> m_tvalid == ($past(res.cnt) != 3'd0))
		else $error("result register load mismatch");

endmodule

/* src/u2a_decode.sv */
// u2a_decode: combinational single-pass decode of one byte against the
// current state, with capacity clamping. Depends on u2a_pkg.
module u2a_decode (
	input  logic [7:0]      in_byte,
	input  logic [15:0]     cap,
	input  u2a_pkg::state_t st,
	output u2a_pkg::state_t st_n,
	output u2a_pkg::res_t   res
);

	logic [16:0] cw_p1;
	logic [16:0] cap17;
	logic [16:0] avail;
	logic        full_pre;
	logic [2:0]  n;
	logic [2:0]  k;
	logic [2:0]  pos;
	logic [2:0]  seen_new;
	logic [20:0] acc_new;
	logic [16:0] cw_next_p1;
	u2a_pkg::xlat_t x;

	assign cw_p1 = {1'b0, st.cw} + 17'd1;
	assign cap17 = {1'b0, cap};
	// room left before the terminator slot
	assign avail = (cw_p1 < cap17) ? (cap17 - cw_p1) : 17'd0;
	assign full_pre = st.full | (cw_p1 >= cap17);
	assign acc_new = {st.accum[14:0], in_byte[5:0]};
	assign seen_new = {1'b0, st.seen} + 3'd1;
	assign x = u2a_pkg::xlat(acc_new);

	always_comb begin
		st_n = st;
		res.chars = {4{u2a_pkg::CH_QMARK}};
		res.cnt = 3'd0;
		res.last = 1'b0;
		n = 3'd0;
		k = 3'd0;
		pos = 3'd0;
		cw_next_p1 = 17'd0;
		if (in_byte == 8'd0) begin
			// flush pending bytes as '?', then terminator if capacity is nonzero
			n = (st.total != 3'd0) ? seen_new : 3'd0;
			if (st.full)
				k = 3'd0;
			else
				k = ({14'd0, n} > avail) ? avail[2:0] : n;
			if (cap != 16'd0) begin
				res.chars[k[1:0]] = u2a_pkg::CH_NUL;
				res.cnt = k + 3'd1;
				res.last = 1'b1;
			end else begin
				res.cnt = k;
			end
			st_n = '0;
		end else if (full_pre) begin
			st_n.full = 1'b1;
		end else begin
			if (st.total != 3'd0 && in_byte[7:6] == 2'b10) begin
				if (seen_new + 3'd1 >= st.total) begin
					st_n.total = 3'd0;
					st_n.seen = 2'd0;
					st_n.accum = '0;
					if (acc_new == u2a_pkg::CP_ELLIPSIS) begin
						res.chars[0] = u2a_pkg::CH_DOT;
						res.chars[1] = u2a_pkg::CH_DOT;
						res.chars[2] = u2a_pkg::CH_DOT;
						n = 3'd3;
					end else if (x.len == 2'd0) begin
						n = 3'd1;
					end else begin
						res.chars[0] = x.c0;
						res.chars[1] = x.c1;
						n = {1'b0, x.len};
					end
				end else begin
					st_n.accum = acc_new;
					st_n.seen = seen_new[1:0];
				end
			end else begin
				// broken sequence: '?' for lead and each continuation
				if (st.total != 3'd0) begin
					pos = seen_new;
					st_n.total = 3'd0;
					st_n.seen = 2'd0;
					st_n.accum = '0;
				end
				n = pos;
				priority if (in_byte[7] == 1'b0) begin
					res.chars[pos[1:0]] = in_byte[6:0];
					n = pos + 3'd1;
				end else if (in_byte[7:5] == 3'b110) begin
					st_n.total = 3'd2;
					st_n.seen = 2'd0;
					st_n.accum = {16'd0, in_byte[4:0]};
				end else if (in_byte[7:4] == 4'b1110) begin
					st_n.total = 3'd3;
					st_n.seen = 2'd0;
					st_n.accum = {17'd0, in_byte[3:0]};
				end else if (in_byte[7:3] == 5'b11110) begin
					st_n.total = 3'd4;
					st_n.seen = 2'd0;
					st_n.accum = {18'd0, in_byte[2:0]};
				end else begin
					n = pos + 3'd1;  // stray byte
				end
			end
			k = ({14'd0, n} > avail) ? avail[2:0] : n;
			st_n.cw = st.cw + {13'd0, k};
			cw_next_p1 = {1'b0, st.cw} + {14'd0, k} + 17'd1;
			st_n.full = (cw_next_p1 >= cap17);
			res.cnt = k;
		end
	end

endmodule

/* src/u2a_outbuf.sv */
// u2a_outbuf: result register holding up to four characters, shifted out
// one transaction per cycle while m_tready is high on the master stream. Depends on u2a_pkg.
module u2a_outbuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  u2a_pkg::res_t res,
	output logic          can_load,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,   // [6:0] out_char, [7] zero
	output logic          m_tlast    // end_of_string
);

	logic [3:0][6:0] chars_q;
	logic            last_q;
	logic [2:0]      rem_q;
	logic [1:0]      rd_q;

	assign m_tvalid = (rem_q != 3'd0);
	assign m_tdata = {1'b0, chars_q[rd_q]};
	assign m_tlast = last_q && (rem_q == 3'd1);
	assign can_load = (rem_q == 3'd0) || (rem_q == 3'd1 && m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
			rd_q <= 2'd0;
		end else if (load) begin
			rem_q <= res.cnt;
			rd_q <= 2'd0;
		end else if (m_tvalid && m_tready) begin
			rem_q <= rem_q - 3'd1;
			rd_q <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			chars_q <= res.chars;
			last_q <= res.last;
		end
	end

endmodule
